FILE: hdl/tkf_pkg.sv
// tilt kalman fusion package: fixed-point constants, unit request/response
// structs, state enums, saturation and the cordic arctangent table
// no dependencies
package tkf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAG_W     = 34;
  localparam int NUM_W     = 48;
  localparam int ANG_W     = 34;
  localparam int DEG_SHIFT = 32 - FRAC_BITS;

  localparam logic signed [31:0] ONE       = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] NINETY    = 32'sd90 <<< FRAC_BITS;
  localparam logic [31:0]        TENTH     = ((32'd1 << FRAC_BITS) + 32'd5) / 32'd10;
  localparam logic [31:0]        ACC_NOISE = 32'd5 << FRAC_BITS;
  localparam logic [MAG_W-1:0]   DT_DIV    = MAG_W'(1000000);
  localparam logic [MAG_W-1:0]   GYRO_DIV  = MAG_W'(656);
  localparam logic [MAG_W-1:0]   DEG_MUL   = MAG_W'(360);

  localparam logic [1:0] REG_RANGE     = 2'd0;
  localparam logic [1:0] REG_GYRO_VAR  = 2'd1;
  localparam logic [1:0] REG_RATE_VAR  = 2'd2;
  localparam logic [1:0] REG_ACCEL_VAR = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } tkf_st_e;

  typedef enum logic [1:0] {
    U_IDLE,
    U_RUN,
    U_FIN
  } unit_st_e;

  typedef enum logic [4:0] {
    OP_DT,
    OP_CRD_R,
    OP_DEG_R,
    OP_CRD_P,
    OP_DEG_P,
    OP_RATE_R,
    OP_RATE_P,
    OP_INT_R,
    OP_INT_P,
    OP_DCR,
    OP_DT_T,
    OP_GNV,
    OP_RNV,
    OP_KX,
    OP_KV,
    OP_COR_R,
    OP_COR_P,
    OP_CA,
    OP_CC,
    OP_CR
  } op_e;

  typedef struct packed {
    logic                    start;
    logic                    deg;
    logic signed [MAG_W-1:0] a;
    logic signed [MAG_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [MAG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] res;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } cor_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ANG_W-1:0] ba;
  } cor_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return {2'b00, v};
  endfunction

endpackage

FILE: hdl/tkf_if.sv
// tilt kalman fusion channel interfaces: raw sample input and filtered output
// valid/ready handshake, no dependencies
interface tkf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic [19:0]        elapsed_us;

  modport source (
    output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_us,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_us,
    output ready
  );
endinterface

interface tkf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] roll_angle;
  logic signed [31:0] pitch_angle;
  logic [16:0]        gain;

  modport source (
    output valid, roll_angle, pitch_angle, gain,
    input  ready
  );
  modport sink (
    input  valid, roll_angle, pitch_angle, gain,
    output ready
  );
endinterface

FILE: hdl/tkf_mul.sv
// bit-serial signed multiplier with rounded right shift and 32-bit saturation
// depends on tkf_pkg
module tkf_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tkf_pkg::mul_req_t req_i,
  output tkf_pkg::mul_rsp_t rsp_o
);
  import tkf_pkg::*;

  localparam int PW = 2 * MAG_W;
  localparam int CW = $clog2(MAG_W);

  unit_st_e         state_q, state_d;
  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [MAG_W-1:0] a_q, b_q;
  logic [PW-1:0]    p_q;
  logic             neg_q, deg_q;
  logic signed [31:0] res_q;

  logic [MAG_W:0]   sum;
  logic [PW-1:0]    rnd, sh;
  logic signed [31:0] res_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      U_IDLE: begin
        if (req_i.start) state_d = U_RUN;
      end
      U_RUN: begin
        if (cnt_q == CW'(MAG_W - 1)) state_d = U_FIN;
      end
      U_FIN: state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_comb begin
    sum = {1'b0, p_q[PW-1:MAG_W]} + (b_q[0] ? {1'b0, a_q} : '0);
    if (deg_q) begin
      rnd = p_q + (PW'(1) << (DEG_SHIFT - 1));
      sh  = rnd >> DEG_SHIFT;
    end else begin
      rnd = p_q + (PW'(1) << (FRAC_BITS - 1));
      sh  = rnd >> FRAC_BITS;
    end
    if (!neg_q) begin
      res_d = (sh > PW'(32'h7fffffff)) ? 32'sh7fffffff : sh[31:0];
    end else begin
      res_d = (sh > PW'(33'h80000000)) ? 32'sh80000000 : -sh[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == U_FIN);
      if (state_q == U_RUN) begin
        cnt_q <= cnt_q + CW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          a_q   <= req_i.a[MAG_W-1] ? -req_i.a : req_i.a;
          b_q   <= req_i.b[MAG_W-1] ? -req_i.b : req_i.b;
          p_q   <= '0;
          neg_q <= req_i.a[MAG_W-1] ^ req_i.b[MAG_W-1];
          deg_q <= req_i.deg;
        end
      end
      U_RUN: begin
        p_q <= {sum, p_q[MAG_W-1:1]};
        b_q <= b_q >> 1;
      end
      U_FIN: res_q <= res_d;
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

FILE: hdl/tkf_div.sv
// bit-serial restoring divider, quotient rounded half away from zero,
// signed result saturated to 32 bits; depends on tkf_pkg
module tkf_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tkf_pkg::div_req_t req_i,
  output tkf_pkg::div_rsp_t rsp_o
);
  import tkf_pkg::*;

  localparam int CW = $clog2(NUM_W);

  unit_st_e         state_q, state_d;
  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [NUM_W-1:0] q_q;
  logic [MAG_W-1:0] d_q, rem_q;
  logic             neg_q;
  logic signed [31:0] res_q;

  logic [MAG_W+1:0] trial;
  logic signed [31:0] res_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      U_IDLE: begin
        if (req_i.start) state_d = U_RUN;
      end
      U_RUN: begin
        if (cnt_q == CW'(NUM_W - 1)) state_d = U_FIN;
      end
      U_FIN: state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_comb begin
    trial = {1'b0, rem_q, q_q[NUM_W-1]} - {2'b00, d_q};
    if (!neg_q) begin
      res_d = (q_q > NUM_W'(32'h7fffffff)) ? 32'sh7fffffff : q_q[31:0];
    end else begin
      res_d = (q_q > NUM_W'(33'h80000000)) ? 32'sh80000000 : -q_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == U_FIN);
      if (state_q == U_RUN) begin
        cnt_q <= cnt_q + CW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          q_q   <= req_i.num + NUM_W'(req_i.den >> 1);
          d_q   <= req_i.den;
          rem_q <= '0;
          neg_q <= req_i.neg;
        end
      end
      U_RUN: begin
        if (!trial[MAG_W+1]) begin
          rem_q <= trial[MAG_W-1:0];
          q_q   <= {q_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[MAG_W-2:0], q_q[NUM_W-1]};
          q_q   <= {q_q[NUM_W-2:0], 1'b0};
        end
      end
      U_FIN: res_q <= res_d;
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

FILE: hdl/tkf_cordic.sv
// iterative vectoring cordic, one micro-rotation per cycle, atan2 in binary
// angle units; depends on tkf_pkg
module tkf_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tkf_pkg::cor_req_t req_i,
  output tkf_pkg::cor_rsp_t rsp_o
);
  import tkf_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS);

  unit_st_e                state_q, state_d;
  logic [CW-1:0]           cnt_q;
  logic                    done_q;
  logic signed [ANG_W-1:0] x_q, y_q, acc_q, ba_q;
  logic                    zero_q;

  logic signed [ANG_W-1:0] xs, ys, shx, shy;
  logic [4:0]              k;

  always_comb begin
    state_d = state_q;
    case (state_q)
      U_IDLE: begin
        if (req_i.start) state_d = U_RUN;
      end
      U_RUN: begin
        if (cnt_q == CW'(CORDIC_STEPS - 1)) state_d = U_FIN;
      end
      U_FIN: state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_comb begin
    xs  = {{2{req_i.x[15]}}, req_i.x, 16'h0000};
    ys  = {{2{req_i.y[15]}}, req_i.y, 16'h0000};
    k   = 5'(cnt_q);
    shx = x_q >>> k;
    shy = y_q >>> k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == U_FIN);
      if (state_q == U_RUN) begin
        cnt_q <= cnt_q + CW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          zero_q <= (req_i.x == 16'sd0) && (req_i.y == 16'sd0);
          if (req_i.x[15]) begin
            x_q   <= -xs;
            y_q   <= -ys;
            acc_q <= req_i.y[15] ? -(ANG_W'(1) <<< 31) : (ANG_W'(1) <<< 31);
          end else begin
            x_q   <= xs;
            y_q   <= ys;
            acc_q <= '0;
          end
        end
      end
      U_RUN: begin
        if (!y_q[ANG_W-1]) begin
          x_q   <= x_q + shy;
          y_q   <= y_q - shx;
          acc_q <= acc_q + atan_lut(k);
        end else begin
          x_q   <= x_q - shy;
          y_q   <= y_q + shx;
          acc_q <= acc_q - atan_lut(k);
        end
      end
      U_FIN: ba_q <= zero_q ? '0 : acc_q;
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ba   = ba_q;

endmodule

FILE: hdl/tilt_kalman_fusion_top.sv
// tilt kalman fusion top: apb registers, operation sequencer and filter state
// depends on tkf_pkg, tkf_if, tkf_mul, tkf_div, tkf_cordic
//
// channel   direction  width  content
// in_i      sink       100    accel x/y/z, gyro x/y, elapsed_us
// out_o     source     81     roll_angle, pitch_angle, gain
// apb       slave      32     gyro_range, three noise variances
//
// one sample runs five serial divides, thirteen serial multiplies and two cordic
// runs, plus the idle and output states, all issued one at a time.
// a new sample is taken once the previous result is in the output register;
// a stalled output holds the next result in the sequencer until the transfer.
// reset restores registers and filter state in the same cycle.
module tilt_kalman_fusion_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tkf_in_if.sink        in_i,
  tkf_out_if.source     out_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import tkf_pkg::*;

  tkf_st_e  state_q, state_d;
  op_e      op_q, op_d;

  logic [1:0]  range_q;
  logic [31:0] gnv_q, rnv_q, anv_q;

  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
  logic [19:0]        us_q;
  logic               started_q;

  logic signed [31:0] roll_q, pitch_q, ca_q, cr_q, cc_q;
  logic signed [31:0] dt_q, rr_q, rp_q, ar_q, ap_q, t_q, kv_q;
  logic signed [ANG_W-1:0] ba_q;
  logic [16:0]        kx_q;

  logic               out_valid_q;
  logic signed [31:0] out_roll_q, out_pitch_q;
  logic [16:0]        out_gain_q;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;
  cor_req_t creq;
  cor_rsp_t crsp;

  logic              use_div, use_cor, unit_done, issue, out_load, wb;
  logic signed [34:0] s;
  logic              s_pos;
  logic [31:0]       ca_mag, cc_mag;
  logic [18:0]       gx5, gy5;
  logic [15:0]       gx_mag, gy_mag;
  logic signed [MAG_W-1:0] omk;
  logic signed [31:0] m, dq;

  tkf_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));
  tkf_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));
  tkf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .req_i(creq), .rsp_o(crsp)
  );

  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_RANGE:     prdata = {30'd0, range_q};
      REG_GYRO_VAR:  prdata = gnv_q;
      REG_RATE_VAR:  prdata = rnv_q;
      REG_ACCEL_VAR: prdata = anv_q;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= '0;
      gnv_q   <= TENTH;
      rnv_q   <= TENTH;
      anv_q   <= ACC_NOISE;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_RANGE:     range_q <= pwdata[1:0];
        REG_GYRO_VAR:  gnv_q   <= pwdata;
        REG_RATE_VAR:  rnv_q   <= pwdata;
        REG_ACCEL_VAR: anv_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // operand selection for the current operation
  always_comb begin
    m  = mrsp.res;
    dq = drsp.res;
    s      = {{3{ca_q[31]}}, ca_q} + {3'b000, anv_q};
    s_pos  = !s[34] && (s != 35'sd0);
    ca_mag = ca_q[31] ? -ca_q : ca_q;
    cc_mag = cc_q[31] ? -cc_q : cc_q;
    gx_mag = gx_q[15] ? -gx_q : gx_q;
    gy_mag = gy_q[15] ? -gy_q : gy_q;
    gx5    = {1'b0, gx_mag, 2'b00} + {3'b000, gx_mag};
    gy5    = {1'b0, gy_mag, 2'b00} + {3'b000, gy_mag};
    omk    = MAG_W'(ONE) - MAG_W'(kx_q);

    use_div = op_q inside {OP_DT, OP_RATE_R, OP_RATE_P, OP_KX, OP_KV};
    use_cor = op_q inside {OP_CRD_R, OP_CRD_P};
    issue   = (state_q == ST_ISSUE);
    unit_done = use_div ? drsp.done : (use_cor ? crsp.done : mrsp.done);

    mreq = '0;
    dreq = '0;
    creq = '0;
    dreq.den = GYRO_DIV;
    case (op_q)
      OP_DT: begin
        dreq.num = started_q ? (NUM_W'(us_q) << FRAC_BITS) : '0;
        dreq.den = DT_DIV;
      end
      OP_CRD_R: begin
        creq.y = az_q;
        creq.x = ay_q;
      end
      OP_CRD_P: begin
        creq.y = az_q;
        creq.x = ax_q;
      end
      OP_DEG_R, OP_DEG_P: begin
        mreq.a   = ba_q;
        mreq.b   = DEG_MUL;
        mreq.deg = 1'b1;
      end
      OP_RATE_R: begin
        dreq.neg = gx_q[15];
        dreq.num = (NUM_W'(gx5) << FRAC_BITS) << range_q;
      end
      OP_RATE_P: begin
        dreq.neg = gy_q[15];
        dreq.num = (NUM_W'(gy5) << FRAC_BITS) << range_q;
      end
      OP_INT_R: begin
        mreq.a = MAG_W'(rr_q);
        mreq.b = MAG_W'(dt_q);
      end
      OP_INT_P: begin
        mreq.a = MAG_W'(rp_q);
        mreq.b = MAG_W'(dt_q);
      end
      OP_DCR: begin
        mreq.a = MAG_W'(dt_q);
        mreq.b = MAG_W'(cr_q);
      end
      OP_DT_T: begin
        mreq.a = MAG_W'(dt_q);
        mreq.b = MAG_W'(t_q);
      end
      OP_GNV: begin
        mreq.a = MAG_W'(dt_q);
        mreq.b = {2'b00, gnv_q};
      end
      OP_RNV: begin
        mreq.a = MAG_W'(dt_q);
        mreq.b = {2'b00, rnv_q};
      end
      OP_KX: begin
        dreq.neg = s_pos && ca_q[31];
        dreq.num = s_pos ? (NUM_W'(ca_mag) << FRAC_BITS) : '0;
        dreq.den = s_pos ? s[MAG_W-1:0] : MAG_W'(1);
      end
      OP_KV: begin
        dreq.neg = s_pos && cc_q[31];
        dreq.num = s_pos ? (NUM_W'(cc_mag) << FRAC_BITS) : '0;
        dreq.den = s_pos ? s[MAG_W-1:0] : MAG_W'(1);
      end
      OP_COR_R: begin
        mreq.a = MAG_W'(ar_q) - MAG_W'(roll_q);
        mreq.b = MAG_W'(kx_q);
      end
      OP_COR_P: begin
        mreq.a = MAG_W'(ap_q) - MAG_W'(pitch_q);
        mreq.b = MAG_W'(kx_q);
      end
      OP_CA: begin
        mreq.a = MAG_W'(ca_q);
        mreq.b = omk;
      end
      OP_CC: begin
        mreq.a = MAG_W'(cc_q);
        mreq.b = omk;
      end
      OP_CR: begin
        mreq.a = MAG_W'(kv_q);
        mreq.b = MAG_W'(cc_q);
      end
      default: ;
    endcase
    mreq.start = issue && !use_div && !use_cor;
    dreq.start = issue && use_div;
    creq.start = issue && use_cor;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    out_load = 1'b0;
    wb       = 1'b0;
    in_i.ready = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_ISSUE;
          op_d    = OP_DT;
        end
      end
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (unit_done) begin
          wb = 1'b1;
          if (op_q == OP_CR) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_ISSUE;
            op_d    = op_e'(op_q + 5'd1);
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_DT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ax_q <= in_i.accel_x;
      ay_q <= in_i.accel_y;
      az_q <= in_i.accel_z;
      gx_q <= in_i.gyro_x;
      gy_q <= in_i.gyro_y;
      us_q <= in_i.elapsed_us;
    end
    if (out_load) begin
      out_roll_q  <= roll_q;
      out_pitch_q <= pitch_q;
      out_gain_q  <= kx_q;
    end
  end

  // filter state and per-operation results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      roll_q    <= '0;
      pitch_q   <= '0;
      ca_q      <= TENTH;
      cr_q      <= TENTH;
      cc_q      <= TENTH;
      dt_q      <= '0;
      rr_q      <= '0;
      rp_q      <= '0;
      ar_q      <= '0;
      ap_q      <= '0;
      t_q       <= '0;
      kv_q      <= '0;
      kx_q      <= '0;
      ba_q      <= '0;
    end else if (wb) begin
      case (op_q)
        OP_DT: begin
          dt_q      <= dq;
          started_q <= 1'b1;
        end
        OP_CRD_R, OP_CRD_P: ba_q <= crsp.ba;
        OP_DEG_R:  ar_q <= sat32(48'(NINETY) - 48'(m));
        OP_DEG_P:  ap_q <= sat32(48'(m) - 48'(NINETY));
        OP_RATE_R: rr_q <= dq;
        OP_RATE_P: rp_q <= dq;
        OP_INT_R:  roll_q <= sat32(48'(roll_q) + 48'(m));
        OP_INT_P:  pitch_q <= sat32(48'(pitch_q) + 48'(m));
        OP_DCR: begin
          t_q  <= sat32((48'(cc_q) <<< 1) + 48'(m));
          cc_q <= sat32(48'(cc_q) + 48'(m));
        end
        OP_DT_T, OP_GNV: ca_q <= sat32(48'(ca_q) + 48'(m));
        OP_RNV: cr_q <= sat32(48'(cr_q) + 48'(m));
        OP_KX: begin
          if (dq[31]) begin
            kx_q <= '0;
          end else if (dq > ONE) begin
            kx_q <= ONE[16:0];
          end else begin
            kx_q <= dq[16:0];
          end
        end
        OP_KV:    kv_q <= dq;
        OP_COR_R: roll_q <= sat32(48'(roll_q) + 48'(m));
        OP_COR_P: pitch_q <= sat32(48'(pitch_q) + 48'(m));
        OP_CA:    ca_q <= m;
        OP_CC:    cc_q <= m;
        OP_CR:    cr_q <= sat32(48'(cr_q) - 48'(m));
        default: ;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.roll_angle  = out_roll_q;
  assign out_o.pitch_angle = out_pitch_q;
  assign out_o.gain        = out_gain_q;

`ifndef SYNTHESIS
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mreq.start || dreq.start || creq.start) |->
      $onehot({mreq.start, dreq.start, creq.start}))
    else $error("more than one unit started");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kx_q <= ONE[16:0])
    else $error("gain above one");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_ISSUE) && (op_q == OP_DT))
    else $error("sample transfer did not start the sequence");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("result not presented after load");
`endif

endmodule
